// File: rtl/tbc_pkg.sv
// Shared types and constants for the triangle backface cull block.
// Used by tbc_front, tbc_queue, tbc_back and triangle_backface_cull.
package tbc_pkg;

  localparam int COORD_BITS_DEF       = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int SCALE_LIMIT          = 30;
  localparam int EYE_W                = SCALE_LIMIT + 1;
  localparam int QUEUE_DEPTH          = 4;

  // configuration register indexes
  localparam logic [1:0] REG_CAMERA_X = 2'd0;
  localparam logic [1:0] REG_CAMERA_Y = 2'd1;
  localparam logic [1:0] REG_CAMERA_Z = 2'd2;

  // classified triangle, handed from front to back
  typedef struct packed {
    logic                              degen;
    logic [2:0]                        c_neg;
    logic [2:0][SCALE_LIMIT-1:0]       c_mag;
    logic [2:0][EYE_W-1:0]             eye;
  } tbc_tri_t;

  typedef struct packed {
    logic full;
    logic empty;
  } tbc_qstat_t;

endpackage

// File: rtl/tbc_front.sv
// Front part: accepts triangles, forms and scales edges and eye vector,
// takes the cross product, normalises it and flags degenerate triangles. Uses tbc_pkg.
module tbc_front #(
  parameter int COORD_BITS = tbc_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [9*COORD_BITS-1:0]      vtx,
  input  logic [2:0][COORD_BITS-1:0]   cam,
  input  tbc_pkg::tbc_qstat_t          q_stat,
  output logic                         q_push,
  output tbc_pkg::tbc_tri_t            q_data
);
  import tbc_pkg::*;

  localparam int DW  = COORD_BITS + 1;
  localparam int ML  = DW;
  localparam int SW  = (ML > SCALE_LIMIT) ? ML : SCALE_LIMIT;
  localparam int LW  = $clog2(SW + 1);
  localparam int PW  = 2 * EYE_W;
  localparam int CSW = PW + 1;
  localparam int CMW = PW;
  localparam int CLW = $clog2(CMW + 1);

  logic en;
  logic [7:1] v_r;

  logic signed [DW-1:0]    d1_r [9];
  logic signed [DW-1:0]    d1_nxt [9];
  logic [ML-1:0]           m2_r [9];
  logic [ML-1:0]           m2_nxt [9];
  logic [8:0]              n2_r, n2_nxt;
  logic [LW-1:0]           sh2_r [3];
  logic [LW-1:0]           sh2_nxt [3];
  logic signed [EYE_W-1:0] s3_r [9];
  logic signed [EYE_W-1:0] s3_nxt [9];
  logic signed [PW-1:0]    p4_r [6];
  logic signed [PW-1:0]    p4_nxt [6];
  logic [2:0][EYE_W-1:0]   e4_r, e5_r, e6_r;
  logic [CMW-1:0]          m5_r [3];
  logic [CMW-1:0]          m5_nxt [3];
  logic [2:0]              n5_r, n5_nxt, n6_r;
  logic [CMW-1:0]          m6_r [3];
  logic [CLW-1:0]          len6_r, len6_nxt;
  logic                    dg6_r, dg6_nxt;
  tbc_tri_t                t7_r, t7_nxt;

  // hold the pipe only when the last stage cannot drain into the queue
  assign en       = !(v_r[7] && q_stat.full);
  assign in_ready = en;
  assign q_push   = v_r[7] && !q_stat.full;
  assign q_data   = t7_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[6:1], in_valid};
    end
  end

  // stage 1: edge and eye differences
  always_comb begin
    logic signed [DW-1:0] p0, p1, p2, pc;
    for (int i = 0; i < 3; i++) begin
      p0 = DW'(signed'(vtx[i*COORD_BITS +: COORD_BITS]));
      p1 = DW'(signed'(vtx[(3+i)*COORD_BITS +: COORD_BITS]));
      p2 = DW'(signed'(vtx[(6+i)*COORD_BITS +: COORD_BITS]));
      pc = DW'(signed'(cam[i]));
      d1_nxt[i]   = p0 - p1;
      d1_nxt[3+i] = p0 - p2;
      d1_nxt[6+i] = p0 - pc;
    end
  end

  // stage 2: magnitudes and per-vector right shift
  always_comb begin
    logic [DW-1:0] t;
    logic [ML-1:0] orv;
    logic [LW-1:0] len;
    for (int v = 0; v < 3; v++) begin
      orv = '0;
      for (int i = 0; i < 3; i++) begin
        n2_nxt[v*3+i] = d1_r[v*3+i][DW-1];
        t = d1_r[v*3+i][DW-1] ? -d1_r[v*3+i] : d1_r[v*3+i];
        m2_nxt[v*3+i] = t;
        orv = orv | t;
      end
      len = '0;
      for (int j = 0; j < ML; j++) begin
        if (orv[j]) len = LW'(j + 1);
      end
      sh2_nxt[v] = (int'(len) > SCALE_LIMIT) ? LW'(int'(len) - SCALE_LIMIT) : '0;
    end
  end

  // stage 3: apply shift, restore sign
  always_comb begin
    logic [SW-1:0]          t;
    logic [EYE_W-1:0]       u;
    for (int v = 0; v < 3; v++) begin
      for (int i = 0; i < 3; i++) begin
        t = SW'(m2_r[v*3+i]) >> sh2_r[v];
        u = {1'b0, t[SCALE_LIMIT-1:0]};
        s3_nxt[v*3+i] = n2_r[v*3+i] ? -signed'(u) : signed'(u);
      end
    end
  end

  // stage 4: cross product terms (a = s3[0..2], b = s3[3..5])
  always_comb begin
    p4_nxt[0] = PW'(s3_r[1]) * PW'(s3_r[5]);
    p4_nxt[1] = PW'(s3_r[2]) * PW'(s3_r[4]);
    p4_nxt[2] = PW'(s3_r[2]) * PW'(s3_r[3]);
    p4_nxt[3] = PW'(s3_r[0]) * PW'(s3_r[5]);
    p4_nxt[4] = PW'(s3_r[0]) * PW'(s3_r[4]);
    p4_nxt[5] = PW'(s3_r[1]) * PW'(s3_r[3]);
  end

  // stage 5: cross components as sign and magnitude
  always_comb begin
    logic signed [CSW-1:0] c;
    logic [CSW-1:0]        t;
    for (int i = 0; i < 3; i++) begin
      c = CSW'(p4_r[2*i]) - CSW'(p4_r[2*i+1]);
      n5_nxt[i] = c[CSW-1];
      t = c[CSW-1] ? -c : c;
      m5_nxt[i] = t[CMW-1:0];
    end
  end

  // stage 6: leading bit of the largest component
  always_comb begin
    logic [CMW-1:0] orv;
    orv = m5_r[0] | m5_r[1] | m5_r[2];
    len6_nxt = '0;
    for (int j = 0; j < CMW; j++) begin
      if (orv[j]) len6_nxt = CLW'(j + 1);
    end
    dg6_nxt = (orv == '0);
  end

  // stage 7: bring the largest component into [2^29, 2^30)
  always_comb begin
    logic [CMW-1:0] t;
    t7_nxt.degen = dg6_r;
    t7_nxt.c_neg = n6_r;
    t7_nxt.eye   = e6_r;
    for (int i = 0; i < 3; i++) begin
      if (int'(len6_r) > SCALE_LIMIT) begin
        t = m6_r[i] >> (int'(len6_r) - SCALE_LIMIT);
      end else begin
        t = m6_r[i] << (SCALE_LIMIT - int'(len6_r));
      end
      t7_nxt.c_mag[i] = t[SCALE_LIMIT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_r   <= d1_nxt;
      m2_r   <= m2_nxt;
      n2_r   <= n2_nxt;
      sh2_r  <= sh2_nxt;
      s3_r   <= s3_nxt;
      p4_r   <= p4_nxt;
      for (int i = 0; i < 3; i++) begin
        e4_r[i] <= s3_r[6+i];
      end
      e5_r   <= e4_r;
      m5_r   <= m5_nxt;
      n5_r   <= n5_nxt;
      e6_r   <= e5_r;
      m6_r   <= m5_r;
      n6_r   <= n5_r;
      len6_r <= len6_nxt;
      dg6_r  <= dg6_nxt;
      t7_r   <= t7_nxt;
    end
  end

endmodule

// File: rtl/tbc_queue.sv
// Short FIFO of classified triangles between front and back parts.
// Uses tbc_pkg for the entry type and depth.
module tbc_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  tbc_pkg::tbc_tri_t   push_data,
  input  logic                pop,
  output tbc_pkg::tbc_tri_t   pop_data,
  output tbc_pkg::tbc_qstat_t stat
);
  import tbc_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);

  tbc_tri_t      mem_r [QUEUE_DEPTH];
  logic [AW-1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;

  assign stat.full  = (cnt_r == (AW+1)'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign pop_data   = mem_r[rd_r];

  always_comb begin
    wr_nxt  = (wr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_r + 1'b1;
    rd_nxt  = (rd_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_r + 1'b1;
    cnt_nxt = cnt_r + (AW+1)'(push) - (AW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) wr_r <= wr_nxt;
      if (pop)  rd_r <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_r] <= push_data;
  end

endmodule

// File: rtl/tbc_back.sv
// Back part: length of the cross product by a pipelined square root, unit
// normal by a pipelined restoring divider, and the sign of dot(n, e). Uses tbc_pkg.
module tbc_back #(
  parameter int NORMAL_FRAC_BITS = tbc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  tbc_pkg::tbc_qstat_t              q_stat,
  input  tbc_pkg::tbc_tri_t                q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [2:0][NORMAL_FRAC_BITS+1:0] normal,
  output logic                             culled
);
  import tbc_pkg::*;

  localparam int F   = NORMAL_FRAC_BITS;
  localparam int NW  = F + 2;
  localparam int QW  = F + 1;
  localparam int SL  = SCALE_LIMIT;
  localparam int SQW = 2 * SL + 2;
  localparam int NS  = SQW / 2;
  localparam int DVW = EYE_W + F + 1;
  localparam int PW  = NW + EYE_W;
  localparam int DSW = PW + 2;

  logic en;

  logic              b1_v_r;
  tbc_tri_t          b1_t_r;
  logic [2*SL-1:0]   b1_sq_r [3];

  logic [SQW:0]      sq_x_r   [NS+1];
  logic [SQW:0]      sq_res_r [NS+1];
  tbc_tri_t          sq_t_r   [NS+1];
  logic [NS:0]       sq_v_r;

  logic [DVW-1:0]    dv_n_r [QW+1][3];
  logic [QW-1:0]     dv_q_r [QW+1][3];
  logic [NS-1:0]     dv_r_r [QW+1];
  tbc_tri_t          dv_t_r [QW+1];
  logic [QW:0]       dv_v_r;

  logic                 d1_v_r;
  logic                 d1_dg_r;
  logic [2:0][NW-1:0]   d1_n_r, d1_n_nxt;
  logic signed [PW-1:0] d1_p_r [3];
  logic signed [PW-1:0] d1_p_nxt [3];

  logic                 o_v_r, o_c_r, o_c_nxt;
  logic [2:0][NW-1:0]   o_n_r;

  // the whole back pipe advances unless a finished word is stuck at the output
  assign en        = !o_v_r || out_ready;
  assign q_pop     = en && !q_stat.empty;
  assign out_valid = o_v_r;
  assign normal    = o_n_r;
  assign culled    = o_c_r;

  // squares of the normalised cross components
  always_ff @(posedge clk) begin
    if (!rst_n) b1_v_r <= 1'b0;
    else if (en) b1_v_r <= !q_stat.empty;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_t_r <= q_data;
      for (int i = 0; i < 3; i++) begin
        b1_sq_r[i] <= (2*SL)'(q_data.c_mag[i]) * (2*SL)'(q_data.c_mag[i]);
      end
    end
  end

  // sum of squares enters the root pipe
  always_ff @(posedge clk) begin
    if (!rst_n) sq_v_r[0] <= 1'b0;
    else if (en) sq_v_r[0] <= b1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_x_r[0]   <= (SQW+1)'(b1_sq_r[0]) + (SQW+1)'(b1_sq_r[1]) + (SQW+1)'(b1_sq_r[2]);
      sq_res_r[0] <= '0;
      sq_t_r[0]   <= b1_t_r;
    end
  end

  // one root bit per stage, from the top bit down
  for (genvar s = 1; s <= NS; s++) begin : gen_sq
    localparam int BP = 2 * (NS - s);
    logic [SQW:0] bitv, trial;
    assign bitv  = (SQW+1)'(1) << BP;
    assign trial = sq_res_r[s-1] + bitv;

    always_ff @(posedge clk) begin
      if (!rst_n) sq_v_r[s] <= 1'b0;
      else if (en) sq_v_r[s] <= sq_v_r[s-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        sq_t_r[s] <= sq_t_r[s-1];
        if (sq_x_r[s-1] >= trial) begin
          sq_x_r[s]   <= sq_x_r[s-1] - trial;
          sq_res_r[s] <= (sq_res_r[s-1] >> 1) + bitv;
        end else begin
          sq_x_r[s]   <= sq_x_r[s-1];
          sq_res_r[s] <= sq_res_r[s-1] >> 1;
        end
      end
    end
  end

  // numerators with half the divisor added for rounding
  always_ff @(posedge clk) begin
    if (!rst_n) dv_v_r[0] <= 1'b0;
    else if (en) dv_v_r[0] <= sq_v_r[NS];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r_r[0] <= sq_res_r[NS][NS-1:0];
      dv_t_r[0] <= sq_t_r[NS];
      for (int i = 0; i < 3; i++) begin
        dv_n_r[0][i] <= (DVW'(sq_t_r[NS].c_mag[i]) << F) + DVW'(sq_res_r[NS][NS-1:1]);
        dv_q_r[0][i] <= '0;
      end
    end
  end

  // one quotient bit per stage
  for (genvar t = 1; t <= QW; t++) begin : gen_dv
    localparam int K = QW - t;
    logic [DVW-1:0] dsr;
    assign dsr = DVW'(dv_r_r[t-1]) << K;

    always_ff @(posedge clk) begin
      if (!rst_n) dv_v_r[t] <= 1'b0;
      else if (en) dv_v_r[t] <= dv_v_r[t-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        dv_r_r[t] <= dv_r_r[t-1];
        dv_t_r[t] <= dv_t_r[t-1];
        for (int i = 0; i < 3; i++) begin
          dv_q_r[t][i] <= dv_q_r[t-1][i] | (QW'(dv_n_r[t-1][i] >= dsr) << K);
          if (dv_n_r[t-1][i] >= dsr) begin
            dv_n_r[t][i] <= dv_n_r[t-1][i] - dsr;
          end else begin
            dv_n_r[t][i] <= dv_n_r[t-1][i];
          end
        end
      end
    end
  end

  // signed normal and its products with the eye vector
  always_comb begin
    logic signed [NW-1:0] n;
    for (int i = 0; i < 3; i++) begin
      n = signed'(NW'(dv_q_r[QW][i]));
      if (dv_t_r[QW].degen) n = '0;
      else if (dv_t_r[QW].c_neg[i]) n = -n;
      d1_n_nxt[i] = n;
      d1_p_nxt[i] = PW'(n) * PW'(signed'(dv_t_r[QW].eye[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) d1_v_r <= 1'b0;
    else if (en) d1_v_r <= dv_v_r[QW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d1_n_r  <= d1_n_nxt;
      d1_p_r  <= d1_p_nxt;
      d1_dg_r <= dv_t_r[QW].degen;
    end
  end

  always_comb begin
    logic signed [DSW-1:0] sum;
    sum = DSW'(d1_p_r[0]) + DSW'(d1_p_r[1]) + DSW'(d1_p_r[2]);
    o_c_nxt = sum[DSW-1] && !d1_dg_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) o_v_r <= 1'b0;
    else if (en) o_v_r <= d1_v_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      o_n_r <= d1_n_r;
      o_c_r <= o_c_nxt;
    end
  end

endmodule

// File: rtl/triangle_backface_cull.sv
// Triangle backface cull: one triangle in, unit face normal and cull flag out.
// Depends on tbc_pkg, tbc_front, tbc_queue and tbc_back.
//
// Takes one triangle per clock while in_tready is high and gives one result
// word per triangle, in order. A 31-stage square root finds the normal's length
// and the restoring divider makes one normal bit per stage. A four-entry
// queue sits between the classifying front pipe and the arithmetic back pipe,
// so input and output stall independently. Camera registers lie at byte
// addresses 0, 4 and 8 (stride 8 when coordinates exceed 32 bits); the user
// must write them only while no triangle is in flight, which the block itself
// does not enforce.
module triangle_backface_cull #(
  parameter int COORD_BITS       = tbc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = tbc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst_n,
  input  logic                                            in_tvalid,
  output logic                                            in_tready,
  // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z from bit 0 up
  input  logic [((9*COORD_BITS+7)/8)*8-1:0]               in_tdata,
  output logic                                            out_tvalid,
  input  logic                                            out_tready,
  // normal_x, normal_y, normal_z from bit 0 up
  output logic [((3*(NORMAL_FRAC_BITS+2)+7)/8)*8-1:0]     out_tdata,
  // culled
  output logic [0:0]                                      out_tuser,
  input  logic                                            psel,
  input  logic                                            penable,
  input  logic                                            pwrite,
  input  logic [((COORD_BITS > 32) ? 5 : 4)-1:0]          paddr,
  input  logic [((COORD_BITS > 32) ? 64 : 32)-1:0]        pwdata,
  output logic [((COORD_BITS > 32) ? 64 : 32)-1:0]        prdata,
  output logic                                            pready
);
  import tbc_pkg::*;

  localparam int CFG_DW = (COORD_BITS > 32) ? 64 : 32;
  localparam int CFG_AW = (COORD_BITS > 32) ? 5 : 4;
  localparam int OUT_W  = ((3*(NORMAL_FRAC_BITS+2)+7)/8)*8;
  localparam int NW     = NORMAL_FRAC_BITS + 2;

  logic [2:0][COORD_BITS-1:0] cam_r;
  logic [1:0]                 cfg_idx;
  logic                       cfg_wr;

  tbc_qstat_t         q_stat;
  tbc_tri_t           q_wdata, q_rdata;
  logic               q_push, q_pop;
  logic [2:0][NW-1:0] normal;
  logic               culled;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[CFG_AW-1:CFG_AW-2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_r <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_CAMERA_X: cam_r[0] <= pwdata[COORD_BITS-1:0];
        REG_CAMERA_Y: cam_r[1] <= pwdata[COORD_BITS-1:0];
        REG_CAMERA_Z: cam_r[2] <= pwdata[COORD_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_CAMERA_X: prdata = CFG_DW'(cam_r[0]);
      REG_CAMERA_Y: prdata = CFG_DW'(cam_r[1]);
      REG_CAMERA_Z: prdata = CFG_DW'(cam_r[2]);
      default:      prdata = '0;
    endcase
  end

  tbc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .vtx      (in_tdata[9*COORD_BITS-1:0]),
    .cam      (cam_r),
    .q_stat   (q_stat),
    .q_push   (q_push),
    .q_data   (q_wdata)
  );

  tbc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .stat      (q_stat)
  );

  tbc_back #(
    .NORMAL_FRAC_BITS (NORMAL_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_stat    (q_stat),
    .q_data    (q_rdata),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .normal    (normal),
    .culled    (culled)
  );

  assign out_tdata    = OUT_W'(normal);
  assign out_tuser[0] = culled;

  localparam logic signed [NW-1:0] N_ONE = signed'(NW'(1) << NORMAL_FRAC_BITS);

  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue written while full");

  a_zero_normal_not_culled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && normal == '0) |-> !culled)
    else $error("degenerate triangle flagged as culled");

  a_normal_unit_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (signed'(normal[0]) <= N_ONE && signed'(normal[0]) >= -N_ONE &&
                    signed'(normal[1]) <= N_ONE && signed'(normal[1]) >= -N_ONE &&
                    signed'(normal[2]) <= N_ONE && signed'(normal[2]) >= -N_ONE))
    else $error("normal component beyond unit length");

endmodule
